FILE: hw/rtl/atan2_pkg.sv
`default_nettype none

package atan2_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS   = 16;
   localparam int ITER_COUNT  = 20;

   localparam int ANGLE_WIDTH = FRAC_BITS + 3;

   // angle arithmetic in Q30
   localparam int ANG_FRAC     = 30;
   localparam int Z_W          = 33;
   localparam int ROUND_SHIFT  = ANG_FRAC - FRAC_BITS;
   localparam int ROUND_HALF   = 1 << (ROUND_SHIFT - 1);

   localparam logic [Z_W-1:0] PI_Q30      = 33'd3373259426;
   localparam logic [Z_W-1:0] HALF_PI_Q30 = 33'd1686629713;

   // leading one of the larger magnitude lands on bit NORM_W-1
   localparam int NORM_W     = 60;
   localparam int VEC_W      = 63;
   localparam int SH_W       = 6;
   localparam int NORM_STEPS = 6;
   localparam int NORM_IDX_W = 3;

   localparam int ITER_W = $clog2(ITER_COUNT);
   localparam int STEP_W = (ITER_W > NORM_IDX_W) ? ITER_W : NORM_IDX_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NORM,
      ST_ROTATE,
      ST_FOLD,
      ST_ROUND
   } state_type;

   typedef struct packed {
      logic                  load;
      logic                  norm;
      logic                  rotate;
      logic [NORM_IDX_W-1:0] norm_sel;
      logic [ITER_W-1:0]     iter;
   } vu_ctrl_type;

   typedef struct packed {
      logic x_neg;
      logic y_neg;
      logic x_zero;
      logic y_zero;
   } quad_flags_type;

   // atan(2^-i) in Q30
   function automatic logic signed [Z_W-1:0] atan_step(input logic [ITER_W-1:0] idx);
      logic [Z_W-1:0] val;
      val = '0;
      case (idx)
         0:  val = 33'h03243F6A8;
         1:  val = 33'h01DAC6705;
         2:  val = 33'h00FADBAFC;
         3:  val = 33'h007F56EA6;
         4:  val = 33'h003FEAB76;
         5:  val = 33'h001FFD55B;
         6:  val = 33'h000FFFAAA;
         7:  val = 33'h0007FFF55;
         8:  val = 33'h0003FFFEA;
         9:  val = 33'h0001FFFFD;
         10: val = 33'h0000FFFFF;
         default: begin
            if (int'(idx) <= ANG_FRAC) begin
               val = Z_W'(1) << (ANG_FRAC - int'(idx));
            end else begin
               val = '0;
            end
         end
      endcase
      return signed'(val);
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/atan2_req_if.sv
`default_nettype none

interface atan2_req_if import atan2_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] x_coord;
   logic signed [COORD_WIDTH-1:0] y_coord;

   modport source (output valid, output x_coord, output y_coord, input ready);
   modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/atan2_rsp_if.sv
`default_nettype none

interface atan2_rsp_if import atan2_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [ANGLE_WIDTH-1:0] angle;

   modport source (output valid, output angle, input ready);
   modport sink   (input valid, input angle, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/atan2_vec_unit.sv
`default_nettype none

module atan2_vec_unit import atan2_pkg::*; (
   input  logic                    clock,
   input  vu_ctrl_type             ctrl,
   input  logic [COORD_WIDTH-1:0]  ax,
   input  logic [COORD_WIDTH-1:0]  ay,
   output logic signed [Z_W-1:0]   z_out
);

   logic signed [VEC_W-1:0] cx_ff, cx_in;
   logic signed [VEC_W-1:0] cy_ff, cy_in;
   logic signed [Z_W-1:0]   z_ff, z_in;

   logic [NORM_W-1:0]       or_bits;
   logic [SH_W-1:0]         norm_amt;
   logic                    norm_ok;
   logic [SH_W-1:0]         rot_sh;
   logic signed [VEC_W-1:0] dx;
   logic signed [VEC_W-1:0] dy;
   logic signed [Z_W-1:0]   t_step;

   always_comb begin
      or_bits  = cx_ff[NORM_W-1:0] | cy_ff[NORM_W-1:0];
      norm_amt = SH_W'(1) << (SH_W'(NORM_STEPS - 1) - SH_W'(ctrl.norm_sel));
      // shift only when the top norm_amt bits of the window are clear
      norm_ok  = (or_bits >> (7'(NORM_W) - 7'(norm_amt))) == '0;

      rot_sh = SH_W'(ctrl.iter);
      dx     = cy_ff >>> rot_sh;
      dy     = cx_ff >>> rot_sh;
      t_step = atan_step(ctrl.iter);

      cx_in = cx_ff;
      cy_in = cy_ff;
      z_in  = z_ff;
      if (ctrl.load) begin
         cx_in = signed'(VEC_W'(ax));
         cy_in = signed'(VEC_W'(ay));
         z_in  = '0;
      end else if (ctrl.norm) begin
         if (norm_ok) begin
            cx_in = cx_ff <<< norm_amt;
            cy_in = cy_ff <<< norm_amt;
         end
      end else if (ctrl.rotate) begin
         if (!cy_ff[VEC_W-1]) begin
            cx_in = cx_ff + dx;
            cy_in = cy_ff - dy;
            z_in  = z_ff + t_step;
         end else begin
            cx_in = cx_ff - dx;
            cy_in = cy_ff + dy;
            z_in  = z_ff - t_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      z_ff  <= z_in;
   end

   assign z_out = z_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/atan2_fold.sv
`default_nettype none

module atan2_fold import atan2_pkg::*; (
   input  quad_flags_type          flags,
   input  logic signed [Z_W-1:0]   z,
   output logic [Z_W-1:0]          mag,
   output logic                    neg
);

   logic [Z_W-1:0] zc;

   always_comb begin
      // clamp the first-quadrant angle to 0 .. pi/2
      if (z[Z_W-1]) begin
         zc = '0;
      end else if (unsigned'(z) > HALF_PI_Q30) begin
         zc = HALF_PI_Q30;
      end else begin
         zc = unsigned'(z);
      end

      if (flags.x_zero && flags.y_zero) begin
         mag = '0;
         neg = 1'b0;
      end else if (flags.x_zero) begin
         mag = HALF_PI_Q30;
         neg = flags.y_neg;
      end else if (flags.y_zero) begin
         mag = flags.x_neg ? PI_Q30 : '0;
         neg = 1'b0;
      end else begin
         mag = flags.x_neg ? (PI_Q30 - zc) : zc;
         neg = flags.y_neg;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/arctangent_two_argument.sv
// Four-quadrant arctangent, Q16 in, Q16 radians out.
// From the input transfer to rsp valid a pair runs through 6 normalize steps,
// ITER_COUNT = 20 CORDIC rotations, a fold state and a rounding state.
// A new pair is accepted only in idle; the shared shift/add unit serves one pair at a time.
// Reset: synchronous, active high; clears the sequencer and the result valid.
`default_nettype none

module arctangent_two_argument import atan2_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   atan2_req_if.sink    req_chan,
   atan2_rsp_if.source  rsp_chan
);

   state_type               state_ff, state_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   quad_flags_type          flags_ff, flags_in;
   logic [Z_W-1:0]          mag_ff;
   logic                    neg_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [ANGLE_WIDTH-1:0]  angle_ff;

   vu_ctrl_type             ctrl;
   logic                    out_load;
   logic                    req_ready;
   logic [COORD_WIDTH-1:0]  x_raw;
   logic [COORD_WIDTH-1:0]  y_raw;
   logic [COORD_WIDTH-1:0]  ax;
   logic [COORD_WIDTH-1:0]  ay;
   logic signed [Z_W-1:0]   z_val;
   logic [Z_W-1:0]          mag_val;
   logic                    neg_val;
   logic [Z_W-1:0]          rnd_sum;
   logic [ANGLE_WIDTH-1:0]  rnd_val;

   // magnitudes of the coordinates; the most negative value maps to 2^(W-1)
   always_comb begin
      x_raw = unsigned'(req_chan.x_coord);
      y_raw = unsigned'(req_chan.y_coord);
      ax    = x_raw[COORD_WIDTH-1] ? (~x_raw + COORD_WIDTH'(1)) : x_raw;
      ay    = y_raw[COORD_WIDTH-1] ? (~y_raw + COORD_WIDTH'(1)) : y_raw;

      flags_in        = flags_ff;
      if (ctrl.load) begin
         flags_in.x_neg  = x_raw[COORD_WIDTH-1];
         flags_in.y_neg  = y_raw[COORD_WIDTH-1];
         flags_in.x_zero = (x_raw == '0);
         flags_in.y_zero = (y_raw == '0);
      end
   end

   // sequencer: load, normalize, rotate, fold, round
   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      ctrl          = '0;
      ctrl.norm_sel = step_ff[NORM_IDX_W-1:0];
      ctrl.iter     = step_ff[ITER_W-1:0];
      req_ready     = 1'b0;
      out_load      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_chan.valid) begin
               ctrl.load = 1'b1;
               step_in   = '0;
               state_in  = ST_NORM;
            end
         end
         ST_NORM: begin
            ctrl.norm = 1'b1;
            if (step_ff == STEP_W'(NORM_STEPS - 1)) begin
               step_in  = '0;
               state_in = ST_ROTATE;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_ROTATE: begin
            ctrl.rotate = 1'b1;
            if (step_ff == STEP_W'(ITER_COUNT - 1)) begin
               step_in  = '0;
               state_in = ST_FOLD;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_FOLD: begin
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   atan2_vec_unit u_vec (
      .clock (clock),
      .ctrl  (ctrl),
      .ax    (ax),
      .ay    (ay),
      .z_out (z_val)
   );

   atan2_fold u_fold (
      .flags (flags_ff),
      .z     (z_val),
      .mag   (mag_val),
      .neg   (neg_val)
   );

   // round half away from zero on the magnitude, then apply the sign
   always_comb begin
      rnd_sum = mag_ff + Z_W'(ROUND_HALF);
      rnd_val = ANGLE_WIDTH'(rnd_sum >> ROUND_SHIFT);
      rsp_valid_in = out_load | (rsp_valid_ff & ~rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      flags_ff <= flags_in;
      if (state_ff == ST_FOLD) begin
         mag_ff <= mag_val;
         neg_ff <= neg_val;
      end
      if (out_load) begin
         angle_ff <= neg_ff ? (~rnd_val + ANGLE_WIDTH'(1)) : rnd_val;
      end
   end

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.angle = signed'(angle_ff);

endmodule

`default_nettype wire
